// File: rtl/trae_pkg.sv
// shared types and constants for the toy register alu executor
// item record passed from the decode front to the execute back, status and op codes
`default_nettype none

package trae_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned NARROW_W    = 8;
    localparam int unsigned IMM_W       = 16;
    localparam int unsigned CODE_W      = 8;
    localparam int unsigned REG_IDX_W   = 3;
    localparam int unsigned NUM_REGS    = 8;

    // register codes
    localparam logic [CODE_W-1:0] NARROW_BASE = 8'h10;
    localparam logic [CODE_W-1:0] IMM_CODE    = 8'h14;

    // action codes at the input
    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;
    localparam logic [1:0] ACT_MOV = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MOV = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DEST_BAD = 2'd1,
        ST_WIDTH    = 2'd2,
        ST_SRC_BAD  = 2'd3
    } t_status;

    // register index: msb set for the narrow bank, low bits select the slot
    typedef struct packed {
        t_status              status;
        t_op                  op;
        logic [REG_IDX_W-1:0] dst_idx;
        logic [REG_IDX_W-1:0] src_idx;
        logic                 src_imm;
        logic [IMM_W-1:0]     imm;
    } t_item;

endpackage

`default_nettype wire

// File: rtl/trae_front.sv
// decode front: splits the input transfer into fields and classifies the instruction
// depends on trae_pkg
`default_nettype none

module trae_front (
    input  wire logic [trae_pkg::IN_TDATA_W-1:0] i_tdata,
    output trae_pkg::t_item                       o_item
);

    logic [1:0]                    w_action;
    logic [trae_pkg::CODE_W-1:0]   w_dcode;
    logic [trae_pkg::CODE_W-1:0]   w_scode;
    logic [trae_pkg::IMM_W-1:0]    w_imm;
    logic                          w_d_wide;
    logic                          w_d_narrow;
    logic                          w_s_wide;
    logic                          w_s_narrow;
    logic                          w_s_imm;

    assign w_action = i_tdata[1:0];
    assign w_dcode  = i_tdata[9:2];
    assign w_scode  = i_tdata[17:10];
    assign w_imm    = i_tdata[33:18];

    always_comb begin
        w_d_wide   = (w_dcode < trae_pkg::NARROW_BASE) && (w_dcode[1:0] == 2'b00);
        w_d_narrow = (w_dcode >= trae_pkg::NARROW_BASE) && (w_dcode < trae_pkg::IMM_CODE);
        w_s_wide   = (w_scode < trae_pkg::NARROW_BASE) && (w_scode[1:0] == 2'b00);
        w_s_narrow = (w_scode >= trae_pkg::NARROW_BASE) && (w_scode < trae_pkg::IMM_CODE);
        w_s_imm    = (w_scode == trae_pkg::IMM_CODE);
    end

    always_comb begin
        o_item.imm     = w_imm;
        o_item.src_imm = w_s_imm;
        o_item.dst_idx = {w_d_narrow, (w_d_narrow ? w_dcode[1:0] : w_dcode[3:2])};
        o_item.src_idx = {w_s_narrow, (w_s_narrow ? w_scode[1:0] : w_scode[3:2])};

        unique case (w_action)
            trae_pkg::ACT_ADD: o_item.op = trae_pkg::OP_ADD;
            trae_pkg::ACT_SUB: o_item.op = trae_pkg::OP_SUB;
            trae_pkg::ACT_MOV: o_item.op = trae_pkg::OP_MOV;
            // unused action code runs as a move
            default:           o_item.op = trae_pkg::OP_MOV;
        endcase

        // destination check first, then source code, then width match
        if (!(w_d_wide || w_d_narrow)) begin
            o_item.status = trae_pkg::ST_DEST_BAD;
        end else if (w_s_imm) begin
            o_item.status = trae_pkg::ST_OK;
        end else if (!(w_s_wide || w_s_narrow)) begin
            o_item.status = trae_pkg::ST_SRC_BAD;
        end else if (w_s_narrow != w_d_narrow) begin
            o_item.status = trae_pkg::ST_WIDTH;
        end else begin
            o_item.status = trae_pkg::ST_OK;
        end
    end

endmodule

`default_nettype wire

// File: rtl/trae_queue.sv
// short first-in first-out queue of decoded items between front and back
// depends on trae_pkg
`default_nettype none

module trae_queue #(
    parameter int unsigned Depth = trae_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire trae_pkg::t_item i_item,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output trae_pkg::t_item      o_item
);

    localparam int unsigned PtrW = $clog2(Depth);
    localparam int unsigned CntW = $clog2(Depth + 1);

    trae_pkg::t_item r_slots [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic [PtrW-1:0] n_wr_ptr;
    logic [PtrW-1:0] n_rd_ptr;
    logic [CntW-1:0] n_count;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slots[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/trae_back.sv
// execute back: register file read stage, alu and write-back into the result register
// depends on trae_pkg
`default_nettype none

module trae_back (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_head_valid,
    input  wire trae_pkg::t_item                   i_head,
    output logic                                   o_pop,
    output logic                                   o_tvalid,
    input  wire logic                              i_tready,
    output logic [trae_pkg::OUT_TDATA_W-1:0]       o_tdata
);

    localparam int unsigned DW = trae_pkg::DATA_W;

    // register file: narrow entries are kept sign-extended to full width
    logic [DW-1:0]                 r_regs [trae_pkg::NUM_REGS];
    logic [trae_pkg::NUM_REGS-1:0] r_regs_valid;

    trae_pkg::t_item               r_item;
    logic                          r_item_valid;
    logic [DW-1:0]                 r_dval;
    logic [DW-1:0]                 r_sval;

    logic                          r_out_valid;
    trae_pkg::t_status             r_out_status;
    logic [DW-1:0]                 r_out_value;

    logic                          w_out_free;
    logic                          w_adv;
    logic [DW-1:0]                 w_operand;
    logic [DW-1:0]                 w_alu;
    logic [DW-1:0]                 w_new;
    logic [DW-1:0]                 w_value;
    logic                          w_wr_en;
    logic [trae_pkg::REG_IDX_W-1:0] w_wr_idx;

    assign w_out_free = !r_out_valid || i_tready;
    assign w_adv      = r_item_valid && w_out_free;
    assign o_pop      = i_head_valid && (!r_item_valid || w_adv);

    always_comb begin
        w_operand = r_item.src_imm ? {{(DW - trae_pkg::IMM_W){r_item.imm[trae_pkg::IMM_W-1]}},
                                      r_item.imm}
                                   : r_sval;
        case (r_item.op)
            trae_pkg::OP_ADD: w_alu = r_dval + w_operand;
            trae_pkg::OP_SUB: w_alu = r_dval - w_operand;
            default:          w_alu = w_operand;
        endcase
        // narrow bank wraps at 8 bits
        w_new = r_item.dst_idx[trae_pkg::REG_IDX_W-1]
              ? {{(DW - trae_pkg::NARROW_W){w_alu[trae_pkg::NARROW_W-1]}},
                 w_alu[trae_pkg::NARROW_W-1:0]}
              : w_alu;
        case (r_item.status)
            trae_pkg::ST_OK:       w_value = w_new;
            trae_pkg::ST_DEST_BAD: w_value = '0;
            default:               w_value = r_dval;
        endcase
        w_wr_en  = w_adv && (r_item.status == trae_pkg::ST_OK);
        w_wr_idx = r_item.dst_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs_valid <= '0;
        end else if (w_wr_en) begin
            r_regs_valid[w_wr_idx] <= 1'b1;
        end
    end

    // register file write and registered reads, forwarding the write of this cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_regs[w_wr_idx] <= w_new;
        end
        if (o_pop) begin
            r_item <= i_head;
            if (w_wr_en && (w_wr_idx == i_head.dst_idx)) begin
                r_dval <= w_new;
            end else if (r_regs_valid[i_head.dst_idx]) begin
                r_dval <= r_regs[i_head.dst_idx];
            end else begin
                r_dval <= '0;
            end
            if (w_wr_en && (w_wr_idx == i_head.src_idx)) begin
                r_sval <= w_new;
            end else if (r_regs_valid[i_head.src_idx]) begin
                r_sval <= r_regs[i_head.src_idx];
            end else begin
                r_sval <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_item_valid <= 1'b1;
            end else if (w_adv) begin
                r_item_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_status <= r_item.status;
            r_out_value  <= w_value;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {{(trae_pkg::OUT_TDATA_W - DW - 2){1'b0}}, r_out_value, r_out_status};

    a_dest_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status == trae_pkg::ST_DEST_BAD) |-> r_out_value == '0)
        else $error("bad destination result carries a nonzero value");

    a_narrow_sext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en && w_wr_idx[trae_pkg::REG_IDX_W-1]
        |-> w_new[DW-1:trae_pkg::NARROW_W]
            == {(DW - trae_pkg::NARROW_W){w_new[trae_pkg::NARROW_W-1]}})
        else $error("narrow register write is not sign-extended");

    a_read_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item_valid && !w_out_free |=> r_item_valid && $stable(r_dval) && $stable(r_sval))
        else $error("read stage operands changed while stalled");

    a_no_write_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (r_item.status != trae_pkg::ST_OK) |=> $stable(r_regs_valid))
        else $error("register file written by a flagged instruction");

endmodule

`default_nettype wire

// File: rtl/toy_register_alu_executor_core.sv
// Register ALU executor: runs one add, subtract or move per transfer on four 32-bit and four
// 8-bit registers and returns a status and the destination's new value. Sustained rate is one
// instruction per clock while the output is not stalled; each result is registered through the
// queue, the read stage and the output register. The rate is set by the back end's read, alu
// and write-back loop, with the write forwarded into the register read of the next instruction.
// Reset clears the register file at once through per-entry valid bits. A short queue between
// decode and execute lets the input keep flowing while a result waits on the output.
// depends on trae_pkg, trae_front, trae_queue, trae_back
`default_nettype none

module toy_register_alu_executor_core #(
    parameter int unsigned QUEUE_DEPTH = trae_pkg::QUEUE_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // action[1:0], dest_code[9:2], src_code[17:10], immediate[33:18], zero pad above
    input  wire logic [trae_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // status[1:0], new_value[33:2], zero pad above
    output logic [trae_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

    trae_pkg::t_item w_dec_item;
    trae_pkg::t_item w_head;
    logic            w_full;
    logic            w_push;
    logic            w_head_valid;
    logic            w_pop;

    assign s_axis_tready = !w_full;
    assign w_push        = s_axis_tvalid && !w_full;

    trae_front u_front (
        .i_tdata (s_axis_tdata),
        .o_item  (w_dec_item)
    );

    trae_queue #(
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_dec_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_item  (w_head)
    );

    trae_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata)
    );

endmodule

`default_nettype wire
